[rtl/vcps_pkg.sv]
package vcps_pkg;

    localparam int LETTERS    = 5;
    localparam int FREQ_W     = 24;
    localparam int SCORE_W    = 16;
    localparam int POS_W      = 32;
    localparam int TOTAL_W    = 18;
    localparam int SUM_W      = 48;
    localparam int SLOPE_W    = 16;
    localparam int OFFSET_W   = 16;
    localparam int LIMIT_W    = 18;
    localparam int COUNT_W    = 3;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // Register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_SLOPE  = 2'd0;
    localparam logic [1:0] REG_OFFSET = 2'd1;
    localparam logic [1:0] REG_LOW    = 2'd2;
    localparam logic [1:0] REG_HIGH   = 2'd3;

    localparam logic [SLOPE_W-1:0]  SLOPE_RESET  = 16'd10798;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'd507;
    localparam logic [LIMIT_W-1:0]  LOW_RESET    = 18'd10;
    localparam logic [LIMIT_W-1:0]  HIGH_RESET   = 18'd90;

    // Coverage classes
    localparam logic [1:0] COV_NONE = 2'd0;
    localparam logic [1:0] COV_LOW  = 2'd1;
    localparam logic [1:0] COV_WELL = 2'd2;
    localparam logic [1:0] COV_OVER = 2'd3;

    typedef struct packed {
        logic [POS_W-1:0]   site_pos;
        logic [1:0]         ref_letter;
        logic [FREQ_W-1:0]  freq_0;
        logic [FREQ_W-1:0]  freq_1;
        logic [FREQ_W-1:0]  freq_2;
        logic [FREQ_W-1:0]  freq_3;
        logic [FREQ_W-1:0]  freq_4;
        logic [SCORE_W-1:0] score_0;
        logic [SCORE_W-1:0] score_1;
        logic [SCORE_W-1:0] score_2;
        logic [SCORE_W-1:0] score_3;
        logic [SCORE_W-1:0] score_4;
    } pos_item_t;

    typedef struct packed {
        logic [SCORE_W-1:0] depth_0;
        logic [SCORE_W-1:0] depth_1;
        logic [SCORE_W-1:0] depth_2;
        logic [SCORE_W-1:0] depth_3;
        logic [SCORE_W-1:0] depth_4;
        logic [LETTERS-1:0] called_mask;
        logic [COUNT_W-1:0] variant_count;
        logic [TOTAL_W-1:0] score_total;
        logic [1:0]         coverage_class;
        logic [TOTAL_W-1:0] peak_total;
        logic [POS_W-1:0]   max_position;
        logic [SUM_W-1:0]   running_total;
    } pos_result_t;

endpackage

[rtl/variant_call_position_stream.sv]
// Variant caller for a stream of genome positions. One request is taken per clock cycle
// while the input is not stalled, and its result passes an input register and a result
// register before it is presented; the rate is set by the path from the
// input register through the frequency sum, the threshold multiply and the five threshold
// compares into the result register. While a result waits to be collected the input
// register can still take one request; the input stalls only when both registers are full
// and the result is stalled. The APB registers lie at byte addresses 0x0 (threshold slope,
// Q0.16), 0x4 (threshold offset, Q8.8), 0x8 (low coverage limit) and 0xC (high coverage
// limit); they should only be written while no request is in flight.
module variant_call_position_stream #(
    parameter int FREQ_FRAC_BITS = 8
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       item_valid,
    output logic                                       item_stall,
    input  vcps_pkg::pos_item_t                        item,
    output logic                                       result_valid,
    input  logic                                       result_stall,
    output vcps_pkg::pos_result_t                      result,
    input  logic                                       psel,
    input  logic                                       penable,
    input  logic                                       pwrite,
    input  logic [vcps_pkg::CFG_ADDR_W-1:0]            paddr,
    input  logic [vcps_pkg::CFG_DATA_W-1:0]            pwdata,
    output logic [vcps_pkg::CFG_DATA_W-1:0]            prdata,
    output logic                                       pready
);
    import vcps_pkg::*;

    localparam int FSUM_W = FREQ_W + 3;
    localparam int TINT_W = FSUM_W - FREQ_FRAC_BITS;
    localparam int PROD_W = SLOPE_W + TINT_W;
    localparam int CMP_W  = PROD_W + FREQ_FRAC_BITS + 1;

    logic [SLOPE_W-1:0]  slope_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [LIMIT_W-1:0]  low_reg;
    logic [LIMIT_W-1:0]  high_reg;

    logic [TOTAL_W-1:0]  best_cov_reg, best_cov_next;
    logic [POS_W-1:0]    best_pos_reg, best_pos_next;
    logic [SUM_W-1:0]    cov_sum_reg, cov_sum_next;

    pos_item_t           item_reg;
    logic                item_valid_reg;
    pos_result_t         result_reg, result_next;
    logic                result_valid_reg;

    logic                adv_out;
    logic                cfg_write;

    logic [FREQ_W-1:0]   freq [LETTERS];
    logic [SCORE_W-1:0]  score [LETTERS];
    logic [FSUM_W-1:0]   fsum;
    logic [TINT_W-1:0]   t_int;
    logic [PROD_W-1:0]   prod;
    logic [CMP_W-1:0]    limit;
    logic [LETTERS-1:0]  call;
    logic [COUNT_W-1:0]  count;
    logic [TOTAL_W-1:0]  total;
    logic [1:0]          cov_class;
    logic [SUM_W:0]      sum_wide;

    assign adv_out      = !result_valid_reg || !result_stall;
    assign item_stall   = item_valid_reg && !adv_out;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign pready       = 1'b1;
    assign cfg_write    = psel && penable && pwrite;

    assign freq[0]  = item_reg.freq_0;
    assign freq[1]  = item_reg.freq_1;
    assign freq[2]  = item_reg.freq_2;
    assign freq[3]  = item_reg.freq_3;
    assign freq[4]  = item_reg.freq_4;
    assign score[0] = item_reg.score_0;
    assign score[1] = item_reg.score_1;
    assign score[2] = item_reg.score_2;
    assign score[3] = item_reg.score_3;
    assign score[4] = item_reg.score_4;

    // Threshold test kept exact: freq * 2^16 against slope * T * 2^F + offset * 2^(8+F).
    always_comb
    begin
        fsum = FSUM_W'(freq[0]) + FSUM_W'(freq[1]) + FSUM_W'(freq[2])
             + FSUM_W'(freq[3]) + FSUM_W'(freq[4]);
        t_int = fsum[FSUM_W-1:FREQ_FRAC_BITS];
        prod  = PROD_W'(slope_reg) * PROD_W'(t_int);
        limit = (CMP_W'(prod) << FREQ_FRAC_BITS)
              + (CMP_W'(offset_reg) << (8 + FREQ_FRAC_BITS));
        count = '0;
        for (int i = 0; i < LETTERS; i++)
        begin
            call[i] = (fsum != '0)
                   && (3'(i) != {1'b0, item_reg.ref_letter})
                   && ((CMP_W'(freq[i]) << 16) > limit)
                   && (score[i] != '0);
            count = count + COUNT_W'(call[i]);
        end
    end

    always_comb
    begin
        total = TOTAL_W'(score[0]) + TOTAL_W'(score[1])
              + TOTAL_W'(score[2]) + TOTAL_W'(score[3]);

        best_cov_next = best_cov_reg;
        best_pos_next = best_pos_reg;
        if (total == '0)
        begin
            cov_class = COV_NONE;
        end
        else if (total < low_reg)
        begin
            cov_class = COV_LOW;
        end
        else if (total < high_reg)
        begin
            cov_class = COV_WELL;
        end
        else
        begin
            cov_class = COV_OVER;
            if (total > best_cov_reg)
            begin
                best_cov_next = total;
                best_pos_next = item_reg.site_pos;
            end
        end

        // A carry out of the sum means it has passed its ceiling.
        sum_wide = {1'b0, cov_sum_reg} + (SUM_W + 1)'(total);
        cov_sum_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

        result_next.depth_0        = call[0] ? score[0] : '0;
        result_next.depth_1        = call[1] ? score[1] : '0;
        result_next.depth_2        = call[2] ? score[2] : '0;
        result_next.depth_3        = call[3] ? score[3] : '0;
        result_next.depth_4        = call[4] ? score[4] : '0;
        result_next.called_mask    = call;
        result_next.variant_count  = count;
        result_next.score_total    = total;
        result_next.coverage_class = cov_class;
        result_next.peak_total     = best_cov_next;
        result_next.max_position   = best_pos_next;
        result_next.running_total  = cov_sum_next;
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_SLOPE:  prdata = CFG_DATA_W'(slope_reg);
            REG_OFFSET: prdata = CFG_DATA_W'(offset_reg);
            REG_LOW:    prdata = CFG_DATA_W'(low_reg);
            REG_HIGH:   prdata = CFG_DATA_W'(high_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_reg  <= SLOPE_RESET;
            offset_reg <= OFFSET_RESET;
            low_reg    <= LOW_RESET;
            high_reg   <= HIGH_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_SLOPE:  slope_reg  <= pwdata[SLOPE_W-1:0];
                REG_OFFSET: offset_reg <= pwdata[OFFSET_W-1:0];
                REG_LOW:    low_reg    <= pwdata[LIMIT_W-1:0];
                REG_HIGH:   high_reg   <= pwdata[LIMIT_W-1:0];
                default:    slope_reg  <= slope_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            best_cov_reg     <= '0;
            best_pos_reg     <= '0;
            cov_sum_reg      <= '0;
        end
        else
        begin
            if (!item_stall)
            begin
                item_valid_reg <= item_valid;
            end
            if (adv_out)
            begin
                result_valid_reg <= item_valid_reg;
                if (item_valid_reg)
                begin
                    best_cov_reg <= best_cov_next;
                    best_pos_reg <= best_pos_next;
                    cov_sum_reg  <= cov_sum_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!item_stall)
        begin
            item_reg <= item;
        end
        if (adv_out && item_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

endmodule

[tb/sv/variant_call_position_stream_tb.sv]
module variant_call_position_stream_tb;
    import vcps_pkg::*;

    localparam int FRAC_BITS = 8;
    localparam int PHASES = 8;
    localparam int SITES_PER_PHASE = 75;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [SUM_W-1:0] SUM_CEILING = {SUM_W{1'b1}};

    // Predicts the call result of every accepted site and checks the results in order.
    class call_scoreboard;
        pos_result_t expected_calls[$];
        logic [SLOPE_W-1:0] slope;
        logic [OFFSET_W-1:0] offset;
        logic [LIMIT_W-1:0] low_limit;
        logic [LIMIT_W-1:0] high_limit;
        logic [TOTAL_W-1:0] best_cov;
        logic [POS_W-1:0] best_pos;
        logic [SUM_W-1:0] cov_sum;
        int mismatches;
        int results_checked;
        int letters_called;
        int over_sites;

        function new();
            slope = SLOPE_RESET;
            offset = OFFSET_RESET;
            low_limit = LOW_RESET;
            high_limit = HIGH_RESET;
            best_cov = '0;
            best_pos = '0;
            cov_sum = '0;
            mismatches = 0;
            results_checked = 0;
            letters_called = 0;
            over_sites = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_SLOPE:  slope = value[SLOPE_W-1:0];
                REG_OFFSET: offset = value[OFFSET_W-1:0];
                REG_LOW:    low_limit = value[LIMIT_W-1:0];
                REG_HIGH:   high_limit = value[LIMIT_W-1:0];
                default:    ;
            endcase
        endfunction

        function void note_site(pos_item_t it);
            logic [FREQ_W-1:0] freq [LETTERS];
            logic [SCORE_W-1:0] score [LETTERS];
            logic [SCORE_W-1:0] depth [LETTERS];
            logic [63:0] fsum;
            logic [63:0] limit;
            logic [TOTAL_W-1:0] total;
            pos_result_t r;
            r = '0;
            freq = '{it.freq_0, it.freq_1, it.freq_2, it.freq_3, it.freq_4};
            score = '{it.score_0, it.score_1, it.score_2, it.score_3, it.score_4};
            fsum = 0;
            for (int i = 0; i < LETTERS; i++)
            begin
                fsum += 64'(freq[i]);
                depth[i] = '0;
            end
            // With no frequency at all nothing is called, but a sum below one still is tested.
            if (fsum != 0)
            begin
                limit = ((64'(slope) * (fsum >> FRAC_BITS)) << FRAC_BITS)
                      + (64'(offset) << (8 + FRAC_BITS));
                for (int i = 0; i < LETTERS; i++)
                begin
                    if (i != int'(it.ref_letter) && (64'(freq[i]) << 16) > limit
                        && score[i] != 0)
                    begin
                        depth[i] = score[i];
                        r.called_mask[i] = 1'b1;
                        r.variant_count = r.variant_count + 1'b1;
                    end
                end
            end
            total = TOTAL_W'(score[0]) + TOTAL_W'(score[1]) + TOTAL_W'(score[2])
                  + TOTAL_W'(score[3]);
            if (total == 0)
                r.coverage_class = COV_NONE;
            else if (total < low_limit)
                r.coverage_class = COV_LOW;
            else if (total < high_limit)
                r.coverage_class = COV_WELL;
            else
            begin
                r.coverage_class = COV_OVER;
                over_sites++;
                if (total > best_cov)
                begin
                    best_cov = total;
                    best_pos = it.site_pos;
                end
            end
            if (cov_sum > SUM_CEILING - SUM_W'(total))
                cov_sum = SUM_CEILING;
            else
                cov_sum = cov_sum + SUM_W'(total);
            r.depth_0 = depth[0];
            r.depth_1 = depth[1];
            r.depth_2 = depth[2];
            r.depth_3 = depth[3];
            r.depth_4 = depth[4];
            r.score_total = total;
            r.peak_total = best_cov;
            r.max_position = best_pos;
            r.running_total = cov_sum;
            letters_called += int'(r.variant_count);
            expected_calls.push_back(r);
        endfunction

        function bit field_ok(string name, logic [63:0] want, logic [63:0] got);
            if (want === got)
                return 1'b1;
            if (mismatches < 10)
                $display("Mismatch on result %0d, %s: expected 0x%0h, got 0x%0h",
                         results_checked, name, want, got);
            return 1'b0;
        endfunction

        function void check_call(pos_result_t got);
            pos_result_t want;
            bit ok;
            if (expected_calls.size() == 0)
            begin
                if (mismatches < 10)
                    $display("Unexpected result with nothing outstanding: 0x%0h", got);
                mismatches++;
                return;
            end
            want = expected_calls.pop_front();
            ok = 1'b1;
            ok &= field_ok("depth_0", want.depth_0, got.depth_0);
            ok &= field_ok("depth_1", want.depth_1, got.depth_1);
            ok &= field_ok("depth_2", want.depth_2, got.depth_2);
            ok &= field_ok("depth_3", want.depth_3, got.depth_3);
            ok &= field_ok("depth_4", want.depth_4, got.depth_4);
            ok &= field_ok("called_mask", want.called_mask, got.called_mask);
            ok &= field_ok("variant_count", want.variant_count, got.variant_count);
            ok &= field_ok("score_total", want.score_total, got.score_total);
            ok &= field_ok("coverage_class", want.coverage_class, got.coverage_class);
            ok &= field_ok("peak_total", want.peak_total, got.peak_total);
            ok &= field_ok("max_position", want.max_position, got.max_position);
            ok &= field_ok("running_total", want.running_total, got.running_total);
            if (!ok)
                mismatches++;
            results_checked++;
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    pos_item_t item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    pos_result_t result;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int cycle_count = 0;
    call_scoreboard sb;

    variant_call_position_stream #(
        .FREQ_FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
        result_stall <= (rx_idle_pct != 0) && ($urandom_range(99) < rx_idle_pct);

    // Both handshakes are sampled here, on the values that held just before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                sb.note_site(item);
            if (result_valid && !result_stall)
                sb.check_call(result);
        end
    end

    // The select is left high so that writes may follow one another directly.
    task automatic write_register(logic [1:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_register(idx, value);
    endtask

    task automatic send_site(pos_item_t it);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    task automatic drain_calls();
        while (sb.expected_calls.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic pos_item_t site(logic [POS_W-1:0] pos, logic [1:0] ref_l,
                                       logic [FREQ_W-1:0] f0, logic [FREQ_W-1:0] f1,
                                       logic [FREQ_W-1:0] f2, logic [FREQ_W-1:0] f3,
                                       logic [FREQ_W-1:0] f4, logic [SCORE_W-1:0] s0,
                                       logic [SCORE_W-1:0] s1, logic [SCORE_W-1:0] s2,
                                       logic [SCORE_W-1:0] s3, logic [SCORE_W-1:0] s4);
        pos_item_t it;
        it.site_pos = pos;
        it.ref_letter = ref_l;
        it.freq_0 = f0;
        it.freq_1 = f1;
        it.freq_2 = f2;
        it.freq_3 = f3;
        it.freq_4 = f4;
        it.score_0 = s0;
        it.score_1 = s1;
        it.score_2 = s2;
        it.score_3 = s3;
        it.score_4 = s4;
        return it;
    endfunction

    function automatic logic [FREQ_W-1:0] pick_freq();
        case ($urandom_range(9))
            0, 1:    return '0;
            2, 3:    return FREQ_W'($urandom_range(255));
            4:       return '1;
            5, 6:    return FREQ_W'($urandom_range(65535));
            default: return FREQ_W'($urandom);
        endcase
    endfunction

    function automatic logic [SCORE_W-1:0] pick_score();
        case ($urandom_range(9))
            0, 1:    return '0;
            2, 3, 4: return SCORE_W'($urandom_range(40));
            5:       return '1;
            6:       return SCORE_W'($urandom_range(300));
            default: return SCORE_W'($urandom);
        endcase
    endfunction

    function automatic pos_item_t random_site();
        logic [POS_W-1:0] pos;
        case ($urandom_range(9))
            0:       pos = '0;
            1:       pos = '1;
            default: pos = POS_W'($urandom);
        endcase
        return site(pos, 2'($urandom_range(3)),
                    pick_freq(), pick_freq(), pick_freq(), pick_freq(), pick_freq(),
                    pick_score(), pick_score(), pick_score(), pick_score(), pick_score());
    endfunction

    initial
    begin
        int unsigned slope_set [PHASES];
        int unsigned offset_set [PHASES];
        int unsigned low_set [PHASES];
        int unsigned high_set [PHASES];
        int tx_pattern [4];
        int rx_pattern [4];
        int sites_sent;
        sb = new();
        tx_pattern = '{0, 53, 0, 16};
        rx_pattern = '{0, 0, 53, 16};
        slope_set = '{10798, 0, 65535, 65535, 0, 0, 0, 0};
        offset_set = '{507, 0, 65535, 0, 65535, 0, 0, 0};
        // The fourth setting puts the low limit above the high one.
        low_set = '{10, 0, 262143, 1000, 1, 0, 0, 0};
        high_set = '{90, 0, 262143, 500, 262143, 0, 0, 0};
        for (int p = 5; p < PHASES; p++)
        begin
            slope_set[p] = $urandom_range(65535);
            offset_set[p] = $urandom_range(2047);
            low_set[p] = $urandom_range(200);
            high_set[p] = low_set[p] + $urandom_range(2000);
        end
        sites_sent = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sites under the reset thresholds: slope about 0.165, offset about 1.98,
        // coverage limits 10 and 90.
        send_site(site(32'd0, 2'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_site(site(32'd1, 2'd1, 0, 0, 0, 0, 0, 3, 3, 3, 0, 0));
        // A non-zero frequency sum below one, so only the offset sets the threshold.
        send_site(site(32'd2, 2'd0, 0, 0, 200, 50, 0, 10, 0, 0, 0, 0));
        send_site(site(32'd3, 2'd1, 0, 0, 0, 0, 0, 40, 40, 9, 0, 0));
        send_site(site(32'd100, 2'd2, 0, 0, 0, 0, 0, 30, 30, 30, 0, 0));
        send_site(site(32'd200, 2'd3, 0, 0, 0, 0, 0, 0, 45, 0, 45, 0));
        send_site(site(32'd300, 2'd0, 0, 0, 0, 0, 0, 91, 0, 0, 0, 0));
        // Letter 1 lands exactly on the threshold, then one step above it.
        send_site(site(32'd4, 2'd0, 26862, 5906, 0, 0, 0, 0, 7, 0, 0, 0));
        send_site(site(32'd5, 2'd0, 26861, 5907, 0, 0, 0, 0, 7, 0, 0, 0));
        send_site(site(32'd6, 2'd2, 0, 0, '1, 0, 0, 0, 0, 500, 0, 0));
        send_site(site(32'd7, 2'd0, 1000, 0, 0, 1000000, 0, 5, 0, 0, 0, 0));
        send_site(site(32'd8, 2'd1, 0, 0, 0, 0, '1, 0, 0, 0, 0, '1));
        send_site(site(32'd9, 2'd3, 24'h400000, 24'h400000, 24'h400000, 0, 24'h400000,
                       1, 2, 3, 4, 5));
        send_site(site('1, 2'd0, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
        send_site(site(32'd10, 2'd1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
        send_site(site(32'd0, 2'd3, 0, 0, 0, 0, 0, '1, '1, '1, '1, '1));
        item_valid <= 1'b0;
        sites_sent = 16;

        for (int p = 0; p < PHASES; p++)
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
            drain_calls();
            write_register(REG_SLOPE, slope_set[p]);
            write_register(REG_OFFSET, offset_set[p]);
            write_register(REG_LOW, low_set[p]);
            write_register(REG_HIGH, high_set[p]);
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            @(posedge clk);
            tx_idle_pct = tx_pattern[p % 4];
            rx_idle_pct = rx_pattern[p % 4];
            for (int n = 0; n < SITES_PER_PHASE; n++)
                send_site(random_site());
            item_valid <= 1'b0;
            sites_sent += SITES_PER_PHASE;
        end

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        while (sb.expected_calls.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d sites under %0d threshold settings and four idling patterns.",
                 sites_sent, PHASES);
        $display("Checked %0d results: %0d letters called, %0d sites overly covered.",
                 sb.results_checked, sb.letters_called, sb.over_sites);
        if (sb.mismatches == 0 && sb.expected_calls.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
